// File: hdl/hpd_pkg.sv
// Shared types, constants and the hex digit function for the polygon point decoder.
// Depends on nothing; every other file of the block imports it.
package hpd_pkg;

   typedef struct packed {
      logic       op;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic [15:0] point_x;
      logic [15:0] point_y;
      logic        is_closing;
   } rsp_type;

   // Unscaled point that leaves the parser, one per request at most.
   typedef struct packed {
      logic       hit;
      logic [7:0] x_byte;
      logic [7:0] y_byte;
      logic       closing;
   } raw_point_type;

   localparam logic       OP_CHAR       = 1'b0;
   localparam logic       OP_END        = 1'b1;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_DOT      = 8'h2E;
   localparam logic [15:0] SCALE_RESET  = 16'd256;

   localparam logic [1:0] POS_X_HIGH    = 2'd0;
   localparam logic [1:0] POS_X_LOW     = 2'd1;
   localparam logic [1:0] POS_Y_HIGH    = 2'd2;
   localparam logic [1:0] POS_Y_LOW     = 2'd3;

   // Characters outside 0-9, A-F and a-f count as the digit zero.
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = c - 8'h41 + 8'd10;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = c - 8'h61 + 8'd10;
      end
      return v[3:0];
   endfunction

endpackage

// File: hdl/hpd_parser.sv
// Character parser of the polygon point decoder: digit position, partial bytes
// and the remembered first point of a contour. Depends on hpd_pkg.
module hpd_parser
   import hpd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          fire,
   input  req_type       req,
   output raw_point_type point
);

   logic [1:0] pos_ff, pos_in;
   logic [7:0] x_ff, x_in;
   logic [7:0] y_ff, y_in;
   logic [7:0] first_x_ff, first_x_in;
   logic [7:0] first_y_ff, first_y_in;
   logic       have_first_ff, have_first_in;
   logic       after_sep_ff, after_sep_in;
   logic [3:0] digit;

   always_comb begin
      pos_in        = pos_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      first_x_in    = first_x_ff;
      first_y_in    = first_y_ff;
      have_first_in = have_first_ff;
      after_sep_in  = after_sep_ff;
      digit         = hex_value(req.char_code);
      point         = '0;

      if (req.op == OP_END) begin
         point.hit     = have_first_ff;
         point.x_byte  = first_x_ff;
         point.y_byte  = first_y_ff;
         point.closing = 1'b1;
         pos_in        = POS_X_HIGH;
         x_in          = 8'd0;
         y_in          = 8'd0;
         first_x_in    = 8'd0;
         first_y_in    = 8'd0;
         have_first_in = 1'b0;
         after_sep_in  = 1'b0;
      end else if (pos_ff == POS_X_HIGH && req.char_code == CHAR_SPACE) begin
         point.hit = 1'b0;
      end else if (pos_ff == POS_X_HIGH && req.char_code == CHAR_DOT) begin
         after_sep_in  = 1'b1;
         point.hit     = have_first_ff;
         point.x_byte  = first_x_ff;
         point.y_byte  = first_y_ff;
         point.closing = 1'b1;
      end else begin
         case (pos_ff)
            POS_X_HIGH: begin
               x_in   = {digit, 4'd0};
               pos_in = POS_X_LOW;
            end
            POS_X_LOW: begin
               x_in   = {x_ff[7:4], digit};
               pos_in = POS_Y_HIGH;
            end
            POS_Y_HIGH: begin
               y_in   = {digit, 4'd0};
               pos_in = POS_Y_LOW;
            end
            default: begin
               y_in          = {y_ff[7:4], digit};
               pos_in        = POS_X_HIGH;
               point.hit     = 1'b1;
               point.x_byte  = x_ff;
               point.y_byte  = y_in;
               point.closing = 1'b0;
               if (after_sep_ff) begin
                  first_x_in    = x_ff;
                  first_y_in    = y_in;
                  have_first_in = 1'b1;
                  after_sep_in  = 1'b0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= POS_X_HIGH;
         x_ff          <= 8'd0;
         y_ff          <= 8'd0;
         first_x_ff    <= 8'd0;
         first_y_ff    <= 8'd0;
         have_first_ff <= 1'b0;
         after_sep_ff  <= 1'b0;
      end else if (fire) begin
         pos_ff        <= pos_in;
         x_ff          <= x_in;
         y_ff          <= y_in;
         first_x_ff    <= first_x_in;
         first_y_ff    <= first_y_in;
         have_first_ff <= have_first_in;
         after_sep_ff  <= after_sep_in;
      end
   end

endmodule

// File: hdl/hpd_scaler.sv
// Scaling stage: multiplies both point bytes by the scale and keeps bits 23:8,
// registered into the result payload. Depends on hpd_pkg.
module hpd_scaler
   import hpd_pkg::*;
(
   input  logic          clock,
   input  logic          load,
   input  raw_point_type point,
   input  logic [15:0]   scale,
   output rsp_type       rsp
);

   logic [23:0] prod_x;
   logic [23:0] prod_y;
   rsp_type     rsp_ff, rsp_in;

   always_comb begin
      prod_x            = {16'd0, point.x_byte} * {8'd0, scale};
      prod_y            = {16'd0, point.y_byte} * {8'd0, scale};
      rsp_in.point_x    = prod_x[23:8];
      rsp_in.point_y    = prod_y[23:8];
      rsp_in.is_closing = point.closing;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

// File: hdl/hex_polygon_point_decoder.sv
// Top level of the polygon point decoder: handshakes, scale register and the
// two-stage pipeline. Depends on hpd_pkg, hpd_parser and hpd_scaler.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_data  (req_type)
//   rsp      out        rsp_valid / rsp_stall  rsp_data  (rsp_type)
//   csr      in         csr_write              csr_wdata (scale)
//
// One request is taken per cycle while req_stall is low; a point passes from the request
// that completes it through the parser register and then the multiplier's register.
// Reset clears the parser state, both stages and sets the scale to 256.
// A stalled result holds its stage, and requests are stalled only when the
// parser register is also full.
module hex_polygon_point_decoder
   import hpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [15:0] csr_wdata
);

   logic          req_fire;
   logic          out_free;
   raw_point_type point;
   raw_point_type s1_ff;
   logic          s1_vld_ff, s1_vld_in;
   logic          rsp_vld_ff, rsp_vld_in;
   logic [15:0]   scale_ff;

   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign req_stall = s1_vld_ff && !out_free;
   assign req_fire  = req_valid && !req_stall;

   hpd_parser u_parser (
      .clock (clock),
      .reset (reset),
      .fire  (req_fire),
      .req   (req_data),
      .point (point)
   );

   always_comb begin
      s1_vld_in  = s1_vld_ff;
      rsp_vld_in = rsp_vld_ff;
      if (out_free) begin
         rsp_vld_in = s1_vld_ff;
         s1_vld_in  = 1'b0;
      end
      if (req_fire) begin
         s1_vld_in = point.hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         scale_ff   <= SCALE_RESET;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_write) begin
            scale_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && point.hit) begin
         s1_ff <= point;
      end
   end

   hpd_scaler u_scaler (
      .clock (clock),
      .load  (out_free && s1_vld_ff),
      .point (s1_ff),
      .scale (scale_ff),
      .rsp   (rsp_data)
   );

   assign rsp_valid = rsp_vld_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_vld_ff && rsp_vld_ff && rsp_stall))
      else $error("request stalled while the pipeline has room");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && out_free) |=> rsp_vld_ff)
      else $error("parser stage lost its point");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_stall && !s1_vld_ff) |=> !rsp_vld_ff)
      else $error("result repeated after it was taken");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_vld_ff && !s1_vld_ff))
      else $error("pipeline not empty after reset");

endmodule

// File: tb/hex_polygon_point_decoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for hex_polygon_point_decoder: drives polygon strings with
// random idling and back-pressure, and checks every point against its own predictor.
// Depends on hpd_pkg and the decoder RTL.
module hex_polygon_point_decoder_tb;
   import hpd_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 12;
   localparam int REPORT_LIMIT = 10;

   class point_scoreboard;
      logic [15:0] scale;
      logic [1:0]  digit_pos;
      logic [7:0]  x_part;
      logic [7:0]  y_part;
      logic [7:0]  first_x;
      logic [7:0]  first_y;
      logic        have_first;
      logic        after_dot;
      rsp_type     expected_points[$];
      int          mismatches;
      int          points_checked;
      int          closings_checked;
      int          requests_noted;

      function new();
         scale = SCALE_RESET;
         clear_contours();
         mismatches = 0;
         points_checked = 0;
         closings_checked = 0;
         requests_noted = 0;
      endfunction

      function void clear_contours();
         digit_pos = POS_X_HIGH;
         x_part = '0;
         y_part = '0;
         first_x = '0;
         first_y = '0;
         have_first = 1'b0;
         after_dot = 1'b0;
      endfunction

      function void set_scale(logic [15:0] value);
         scale = value;
      endfunction

      function int pending();
         return expected_points.size();
      endfunction

      function logic [15:0] scaled(logic [7:0] coord);
         logic [23:0] product;
         product = {16'd0, coord} * {8'd0, scale};
         return product[23:8];
      endfunction

      function logic [3:0] digit_of(logic [7:0] c);
         if (c inside {[8'h30:8'h39]}) begin
            return c[3:0];
         end
         if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            return c[3:0] + 4'd9;
         end
         return 4'd0;
      endfunction

      function void push_point(logic [7:0] x, logic [7:0] y, logic closing);
         rsp_type p;
         p.point_x = scaled(x);
         p.point_y = scaled(y);
         p.is_closing = closing;
         expected_points.push_back(p);
      endfunction

      function void note_request(req_type r);
         logic [3:0] d;
         requests_noted++;
         if (r.op == OP_END) begin
            if (have_first) begin
               push_point(first_x, first_y, 1'b1);
            end
            clear_contours();
            return;
         end
         if (digit_pos == POS_X_HIGH && r.char_code == CHAR_SPACE) begin
            return;
         end
         if (digit_pos == POS_X_HIGH && r.char_code == CHAR_DOT) begin
            after_dot = 1'b1;
            if (have_first) begin
               push_point(first_x, first_y, 1'b1);
            end
            return;
         end
         d = digit_of(r.char_code);
         case (digit_pos)
            POS_X_HIGH: begin
               x_part = {d, 4'h0};
               digit_pos = POS_X_LOW;
            end
            POS_X_LOW: begin
               x_part[3:0] = d;
               digit_pos = POS_Y_HIGH;
            end
            POS_Y_HIGH: begin
               y_part = {d, 4'h0};
               digit_pos = POS_Y_LOW;
            end
            default: begin
               y_part[3:0] = d;
               digit_pos = POS_X_HIGH;
               push_point(x_part, y_part, 1'b0);
               if (after_dot) begin
                  first_x = x_part;
                  first_y = y_part;
                  have_first = 1'b1;
                  after_dot = 1'b0;
               end
            end
         endcase
      endfunction

      function void check_point(rsp_type got);
         rsp_type want;
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("Unexpected point: x=%0d y=%0d closing=%0b",
                        got.point_x, got.point_y, got.is_closing);
            end
            return;
         end
         want = expected_points.pop_front();
         points_checked++;
         if (want.is_closing) begin
            closings_checked++;
         end
         if (got.point_x !== want.point_x || got.point_y !== want.point_y ||
             got.is_closing !== want.is_closing) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("Mismatch: expected x=%0d y=%0d c=%0b, got x=%0d y=%0d c=%0b",
                        want.point_x, want.point_y, want.is_closing,
                        got.point_x, got.point_y, got.is_closing);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_write;
   logic [15:0] csr_wdata;

   point_scoreboard board = new();
   int sender_idle_pct;
   int receiver_idle_pct;
   int hold_requested;
   int hold_done;
   int cycle_count;
   int scale_writes;

   hex_polygon_point_decoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run stopped at the cycle limit with %0d points outstanding.", board.pending());
      $display("TEST FAILED");
      $finish;
   end

   // The receiver stalls at random, or for one long stretch when a hold is requested.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_done < hold_requested) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_done++;
         end else begin
            rsp_stall = ($urandom_range(99) < receiver_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_point(rsp_data);
      end
   end

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic send_request(req_type r);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = r;
      do begin
         @(posedge clock);
      end while (req_stall);
      board.note_request(r);
      @(negedge clock);
   endtask

   task automatic send_char(logic [7:0] c);
      req_type r;
      r.op = OP_CHAR;
      r.char_code = c;
      send_request(r);
   endtask

   task automatic send_end();
      req_type r;
      r.op = OP_END;
      r.char_code = 8'($urandom_range(255));
      send_request(r);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i]);
      end
   endtask

   function automatic logic [7:0] random_hex_char();
      logic [7:0] n;
      n = 8'($urandom_range(15));
      if (n < 8'd10) begin
         return 8'h30 + n;
      end
      if ($urandom_range(1) == 1) begin
         return 8'h41 + n - 8'd10;
      end
      return 8'h61 + n - 8'd10;
   endfunction

   task automatic send_point();
      repeat (4) send_char(random_hex_char());
   endtask

   task automatic send_polygon_string();
      int contours;
      int points;
      contours = $urandom_range(1, 3);
      for (int k = 0; k < contours; k++) begin
         points = $urandom_range(1, 4);
         for (int p = 0; p < points; p++) begin
            if ($urandom_range(3) == 0) begin
               send_char(CHAR_SPACE);
            end
            send_point();
         end
         repeat ($urandom_range(2, (k == contours - 1) ? 0 : 1)) send_char(CHAR_DOT);
      end
      send_end();
   endtask

   // Valid points and dots, then a point of arbitrary characters cut short or not.
   task automatic send_broken_string();
      repeat ($urandom_range(1, 3)) begin
         if ($urandom_range(2) == 0) begin
            send_char(CHAR_DOT);
         end else begin
            send_point();
         end
      end
      repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(255)));
      send_end();
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 6)) begin
         if ($urandom_range(7) == 0) begin
            send_end();
         end else begin
            send_char(8'($urandom_range(255)));
         end
      end
   endtask

   task automatic run_phase(int count);
      int target;
      int pick;
      target = board.requests_noted + count;
      while (board.requests_noted < target) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            send_polygon_string();
         end else if (pick < 90) begin
            send_broken_string();
         end else begin
            send_noise();
         end
      end
   endtask

   task automatic write_scale(logic [15:0] value);
      req_valid = 1'b0;
      while (board.pending() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_write = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_write = 1'b0;
      board.set_scale(value);
      scale_writes++;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_wdata = '0;
      sender_idle_pct = 6;
      receiver_idle_pct = 61;
      hold_requested = 0;
      hold_done = 0;
      scale_writes = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // A point before any dot is never remembered, so the first dot closes nothing.
      send_text("FF00");
      send_text(".");
      send_text(" ");
      send_text("a0Bf");
      // Characters that are not hex digits, a space among them, decode as zero.
      send_text("zG9 ");
      send_text("..");
      // The cut-off point is dropped and the end closes the contour; a second end is silent.
      send_text("12");
      send_end();
      send_end();

      write_scale(16'h0000);
      run_phase(100);
      write_scale(16'hFFFF);
      run_phase(500);

      sender_idle_pct = 61;
      receiver_idle_pct = 6;
      write_scale(16'($urandom_range(16'hFFFF)));
      run_phase(600);

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      write_scale(16'($urandom_range(16'hFFFF, 1)));
      hold_requested = 1;
      run_phase(600);

      req_valid = 1'b0;
      while (board.pending() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Decoded %0d requests under %0d scale settings in %0d cycles.",
               board.requests_noted, scale_writes + 1, cycle_count);
      $display("Checked %0d points, %0d of them contour closings; %0d mismatches.",
               board.points_checked, board.closings_checked, board.mismatches);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
